// File: design/ntt_256_q3329_engine_top_defines.svh
// assertion macros for the transform engine checker
`ifndef NTT_256_Q3329_ENGINE_TOP_DEFINES_SVH
`define NTT_256_Q3329_ENGINE_TOP_DEFINES_SVH

// condition must hold in the same cycle
`define NTTE_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the next cycle
`define NTTE_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ntte_pkg.sv
package ntte_pkg;

  localparam int unsigned NPTS = 256;
  localparam int unsigned HALF_N = 128;
  localparam logic [11:0] MOD_Q = 12'd3329;
  localparam logic [12:0] BAR_M = 13'd5039;
  localparam int unsigned BAR_SHIFT = 24;
  localparam int unsigned ROOT = 17;
  localparam logic [11:0] N_INV = 12'd3316;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_XFORM = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RDVAL,
    ST_RDA,
    ST_RDB,
    ST_OP,
    ST_WAIT,
    ST_WRB
  } state_t;

  typedef enum logic [1:0] {
    PH_BFLY,
    PH_SCALE,
    PH_PERM
  } phase_t;

  typedef logic [11:0] tw_arr_t [HALF_N];

  typedef struct packed {
    logic [7:0]  addr_a;
    logic [7:0]  addr_b;
    logic [11:0] tw;
    logic        swap;
  } agu_t;

  typedef struct packed {
    logic        start;
    logic [11:0] a;
    logic [11:0] b;
  } mul_req_t;

  function automatic tw_arr_t tw_build();
    tw_arr_t t;
    int unsigned p;
    p = 1;
    for (int i = 0; i < HALF_N; i++) begin
      t[i] = 12'(p);
      p = (p * ROOT) % MOD_Q;
    end
    return t;
  endfunction

  // powers of 17 mod q
  localparam tw_arr_t TW = tw_build();

endpackage

// File: design/ntte_ram.sv
module ntte_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ntte_mulred.sv
module ntte_mulred (
  input  logic               clk,
  input  logic               rst_n,
  input  ntte_pkg::mul_req_t req,
  output logic               done,
  output logic [11:0]        res
);

  logic [3:0]  vld_r;
  logic [3:0]  vld_nxt;
  logic [23:0] p1_r;
  logic [23:0] p2_r;
  logic [12:0] e2_r;
  logic [13:0] r3_r;
  logic [11:0] r4_r;
  logic [36:0] bar_prod;
  logic [24:0] eq_prod;
  logic [13:0] r_a;
  logic [13:0] r_b;

  assign vld_nxt = {vld_r[2:0], req.start};

  always_comb begin
    bar_prod = {13'd0, p1_r} * {24'd0, ntte_pkg::BAR_M};
    eq_prod = {12'd0, e2_r} * {13'd0, ntte_pkg::MOD_Q};
    r_a = (r3_r >= {2'd0, ntte_pkg::MOD_Q}) ? r3_r - {2'd0, ntte_pkg::MOD_Q} : r3_r;
    r_b = (r_a >= {2'd0, ntte_pkg::MOD_Q}) ? r_a - {2'd0, ntte_pkg::MOD_Q} : r_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    p1_r <= {12'd0, req.a} * {12'd0, req.b};
    p2_r <= p1_r;
    e2_r <= bar_prod[ntte_pkg::BAR_SHIFT +: 13];
    r3_r <= 14'(({1'b0, p2_r} - eq_prod));
    r4_r <= r_b[11:0];
  end

  assign done = vld_r[3];
  assign res = r4_r;

endmodule

// File: design/ntte_agu.sv
module ntte_agu (
  input  ntte_pkg::phase_t phase,
  input  logic [2:0]       stage,
  input  logic [7:0]       cnt,
  input  logic             inv,
  output ntte_pkg::agu_t   ag
);

  logic [6:0] b7;
  logic [6:0] mask;
  logic [6:0] off;
  logic [6:0] k;
  logic [6:0] kneg;
  logic [7:0] top;
  logic [7:0] hbit;
  logic [7:0] rev;
  logic [11:0] tw_f;

  always_comb begin
    b7 = cnt[6:0];
    mask = 7'((8'd1 << stage) - 8'd1);
    off = b7 & mask;
    top = {b7 & ~mask, 1'b0} | {1'b0, off};
    hbit = 8'd1 << stage;
    k = 7'(off << (3'd7 - stage));
    kneg = 7'(~k + 7'd1);
    for (int i = 0; i < 8; i++) begin
      rev[i] = cnt[7 - i];
    end
    if (inv && k != 7'd0) begin
      tw_f = ntte_pkg::MOD_Q - ntte_pkg::TW[kneg];
    end else begin
      tw_f = ntte_pkg::TW[k];
    end
    ag = '0;
    case (phase)
      ntte_pkg::PH_BFLY: begin
        ag.addr_a = top;
        ag.addr_b = top | hbit;
        ag.tw = tw_f;
      end
      ntte_pkg::PH_SCALE: begin
        ag.addr_a = cnt;
        ag.addr_b = cnt;
        ag.tw = ntte_pkg::N_INV;
      end
      ntte_pkg::PH_PERM: begin
        ag.addr_a = cnt;
        ag.addr_b = rev;
        ag.swap = rev > cnt;
      end
      default: begin
        ag = '0;
      end
    endcase
  end

endmodule

// File: design/ntt_256_q3329_engine_top.sv
// channel | ports                        | payload
// in      | in_tvalid/in_tready          | tuser operation, tdata index + value
// out     | out_tvalid/out_tready        | tuser transform_done, tdata value + index
// cfg     | cfg_valid/cfg_ready          | cfg_data inverse_mode
// write goes straight to the ram; read passes the RDVAL state, then the output handoff
// transform uses one shared mod-mult unit and one ram read port; each butterfly reads
// both words, writes the sum, then writes the product once the multiplier is done
// after reset a clearing pass zeroes all 256 words before the first word is taken
// input stalls while a result word waits unless it is taken in that cycle
module ntt_256_q3329_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // operation
  input  logic [23:0] in_tdata,   // index, value, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // transform_done
  output logic [23:0] out_tdata,  // read_value, read_index, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // inverse_mode
);

  ntte_pkg::state_t state_r, state_nxt;
  ntte_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  stage_r, stage_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [11:0] a_r, a_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic        inv_r;
  logic        ov_r, ov_nxt;
  logic        ou_r, ou_nxt;
  logic [11:0] oval_r, oval_nxt;
  logic [7:0]  oidx_r, oidx_nxt;

  logic        we;
  logic [7:0]  waddr;
  logic [11:0] wdata;
  logic [7:0]  raddr;
  logic [11:0] rdata;
  ntte_pkg::agu_t   ag;
  ntte_pkg::mul_req_t mreq;
  logic        mdone;
  logic [11:0] mres;

  logic        acc;
  logic        last;
  logic [7:0]  in_idx;
  logic [11:0] in_val;
  logic [12:0] sum_w;
  logic [13:0] dif_w;
  logic [11:0] sum_m;
  logic [11:0] dif_m;

  ntte_ram #(.WIDTH(12), .DEPTH(256)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  ntte_agu u_agu (
    .phase(phase_r), .stage(stage_r), .cnt(cnt_r), .inv(inv_r), .ag(ag)
  );

  ntte_mulred u_mul (
    .clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .res(mres)
  );

  assign in_idx = in_tdata[7:0];
  assign in_val = in_tdata[19:8];
  assign in_tready = (state_r == ntte_pkg::ST_IDLE) && (!ov_r || out_tready);
  assign acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign last = (phase_r == ntte_pkg::PH_BFLY) ? (cnt_r[6:0] == 7'h7f) : (cnt_r == 8'hff);

  assign out_tvalid = ov_r;
  assign out_tuser = ou_r;
  assign out_tdata = {4'd0, oidx_r, oval_r};

  always_comb begin
    sum_w = {1'b0, a_r} + {1'b0, rdata};
    sum_m = (sum_w >= {1'b0, ntte_pkg::MOD_Q}) ? 12'(sum_w - {1'b0, ntte_pkg::MOD_Q})
                                                : sum_w[11:0];
    dif_w = {2'd0, a_r} + {2'd0, ntte_pkg::MOD_Q} - {2'd0, rdata};
    dif_m = (dif_w >= {2'd0, ntte_pkg::MOD_Q}) ? 12'(dif_w - {2'd0, ntte_pkg::MOD_Q})
                                                : dif_w[11:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ntte_pkg::ST_CLR: begin
        if (cnt_r == 8'hff) state_nxt = ntte_pkg::ST_IDLE;
      end
      ntte_pkg::ST_IDLE: begin
        if (acc && in_tuser == ntte_pkg::OP_XFORM) state_nxt = ntte_pkg::ST_RDA;
        else if (acc && in_tuser == ntte_pkg::OP_READ) state_nxt = ntte_pkg::ST_RDVAL;
      end
      ntte_pkg::ST_RDVAL: state_nxt = ntte_pkg::ST_IDLE;
      ntte_pkg::ST_RDA: state_nxt = ntte_pkg::ST_RDB;
      ntte_pkg::ST_RDB: state_nxt = ntte_pkg::ST_OP;
      ntte_pkg::ST_OP: begin
        if (phase_r != ntte_pkg::PH_PERM) state_nxt = ntte_pkg::ST_WAIT;
        else if (ag.swap) state_nxt = ntte_pkg::ST_WRB;
        else if (last) state_nxt = ntte_pkg::ST_IDLE;
        else state_nxt = ntte_pkg::ST_RDA;
      end
      ntte_pkg::ST_WAIT: begin
        if (mdone) state_nxt = ntte_pkg::ST_RDA;
      end
      ntte_pkg::ST_WRB: begin
        state_nxt = last ? ntte_pkg::ST_IDLE : ntte_pkg::ST_RDA;
      end
      default: state_nxt = ntte_pkg::ST_CLR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    logic adv;
    adv = 1'b0;
    we = 1'b0;
    waddr = ag.addr_b;
    wdata = mres;
    raddr = ag.addr_a;
    mreq = '0;
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    cnt_nxt = cnt_r;
    a_nxt = a_r;
    idx_nxt = idx_r;
    ov_nxt = ov_r && !out_tready;
    ou_nxt = ou_r;
    oval_nxt = oval_r;
    oidx_nxt = oidx_r;
    case (state_r)
      ntte_pkg::ST_CLR: begin
        we = 1'b1;
        waddr = cnt_r;
        wdata = '0;
        cnt_nxt = cnt_r + 8'd1;
      end
      ntte_pkg::ST_IDLE: begin
        raddr = in_idx;
        if (acc) begin
          case (in_tuser)
            ntte_pkg::OP_WRITE: begin
              we = 1'b1;
              waddr = in_idx;
              wdata = (in_val >= ntte_pkg::MOD_Q) ? in_val - ntte_pkg::MOD_Q : in_val;
            end
            ntte_pkg::OP_XFORM: begin
              phase_nxt = ntte_pkg::PH_BFLY;
              stage_nxt = 3'd7;
              cnt_nxt = '0;
            end
            ntte_pkg::OP_READ: idx_nxt = in_idx;
            default: ;
          endcase
        end
      end
      ntte_pkg::ST_RDVAL: begin
        ov_nxt = 1'b1;
        ou_nxt = 1'b0;
        oval_nxt = rdata;
        oidx_nxt = idx_r;
      end
      ntte_pkg::ST_RDA: raddr = ag.addr_a;
      ntte_pkg::ST_RDB: begin
        raddr = ag.addr_b;
        a_nxt = rdata;
      end
      ntte_pkg::ST_OP: begin
        case (phase_r)
          ntte_pkg::PH_BFLY: begin
            we = 1'b1;
            waddr = ag.addr_a;
            wdata = sum_m;
            mreq.start = 1'b1;
            mreq.a = dif_m;
            mreq.b = ag.tw;
          end
          ntte_pkg::PH_SCALE: begin
            mreq.start = 1'b1;
            mreq.a = a_r;
            mreq.b = ag.tw;
          end
          default: begin
            if (ag.swap) begin
              we = 1'b1;
              waddr = ag.addr_a;
              wdata = rdata;
            end else begin
              adv = 1'b1;
            end
          end
        endcase
      end
      ntte_pkg::ST_WAIT: begin
        if (mdone) begin
          we = 1'b1;
          waddr = ag.addr_b;
          wdata = mres;
          adv = 1'b1;
        end
      end
      ntte_pkg::ST_WRB: begin
        we = 1'b1;
        waddr = ag.addr_b;
        wdata = a_r;
        adv = 1'b1;
      end
      default: ;
    endcase
    if (adv) begin
      if (!last) begin
        cnt_nxt = cnt_r + 8'd1;
      end else begin
        cnt_nxt = '0;
        case (phase_r)
          ntte_pkg::PH_BFLY: begin
            if (stage_r != 3'd0) stage_nxt = stage_r - 3'd1;
            else phase_nxt = inv_r ? ntte_pkg::PH_SCALE : ntte_pkg::PH_PERM;
          end
          ntte_pkg::PH_SCALE: phase_nxt = ntte_pkg::PH_PERM;
          default: begin
            ov_nxt = 1'b1;
            ou_nxt = 1'b1;
            oval_nxt = '0;
            oidx_nxt = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntte_pkg::ST_CLR;
      phase_r <= ntte_pkg::PH_BFLY;
      stage_r <= '0;
      cnt_r <= '0;
      inv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) inv_r <= cfg_data;
    end
    a_r <= a_nxt;
    idx_r <= idx_nxt;
    ou_r <= ou_nxt;
    oval_r <= oval_nxt;
    oidx_r <= oidx_nxt;
  end

endmodule

// File: design/ntte_chk.sv
`include "ntt_256_q3329_engine_top_defines.svh"

module ntte_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic [23:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tuser,
  input logic [23:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_data
);

  `NTTE_CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result word dropped")
  `NTTE_CHK_NOW(a_ack_zero, out_tvalid && out_tuser, out_tdata == 24'd0, "ack word not zero")
  `NTTE_CHK_NOW(a_val_range, out_tvalid && !out_tuser, out_tdata[11:0] < ntte_pkg::MOD_Q, "value out of range")
  `NTTE_CHK_NEXT(a_wr_silent, in_tvalid && in_tready && in_tuser == ntte_pkg::OP_WRITE && !out_tvalid, !out_tvalid, "write made a result")
  `NTTE_CHK_NOW(a_rdy_free, in_tready, !out_tvalid || out_tready, "input taken with output blocked")

endmodule

bind ntt_256_q3329_engine_top ntte_chk u_chk (.*);

// File: sim/tb_ntt_256_q3329_engine_top.sv
module tb_ntt_256_q3329_engine_top;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [11:0] val;
  } cmd_t;

  typedef struct {
    logic [11:0] value;
    logic [7:0]  index;
    logic        done;
  } rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic        out_tuser;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  cmd_t        cmd_q[$];
  rsp_t        rsp_q[$];
  logic [11:0] coef[ntte_pkg::NPTS];
  logic        inv_mode;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cnt;
  int          hold_req;
  int          errors;
  int          n_xform;
  int          n_read;
  int          n_write;
  int          cycles;

  ntt_256_q3329_engine_top dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // exact model of the transform over the coefficient copy
  task automatic run_ntt();
    int pw[ntte_pkg::HALF_N];
    int half, grp, off, top, bot, k, a, b, sm, df, w, j;
    logic [11:0] tmp;
    pw[0] = 1;
    for (int i = 1; i < ntte_pkg::HALF_N; i++)
      pw[i] = (pw[i - 1] * ntte_pkg::ROOT) % ntte_pkg::MOD_Q;
    for (int s = 7; s >= 0; s--) begin
      half = 1 << s;
      for (int bf = 0; bf < ntte_pkg::HALF_N; bf++) begin
        grp = bf / half;
        off = bf % half;
        top = grp * 2 * half + off;
        bot = top + half;
        k = off * (ntte_pkg::HALF_N / half);
        a = coef[top];
        b = coef[bot];
        sm = (a + b) % ntte_pkg::MOD_Q;
        df = (a + ntte_pkg::MOD_Q - b) % ntte_pkg::MOD_Q;
        w = pw[k];
        if (inv_mode && k > 0) w = ntte_pkg::MOD_Q - pw[ntte_pkg::HALF_N - k];
        coef[top] = 12'(sm);
        coef[bot] = 12'((df * w) % ntte_pkg::MOD_Q);
      end
    end
    if (inv_mode)
      for (int i = 0; i < ntte_pkg::NPTS; i++)
        coef[i] = 12'((int'(coef[i]) * ntte_pkg::N_INV) % ntte_pkg::MOD_Q);
    for (int i = 0; i < ntte_pkg::NPTS; i++) begin
      j = 0;
      for (int bb = 0; bb < 8; bb++) j = (j << 1) | ((i >> bb) & 1);
      if (j > i) begin
        tmp = coef[i];
        coef[i] = coef[j];
        coef[j] = tmp;
      end
    end
  endtask

  task automatic apply_cmd(cmd_t c);
    rsp_t r;
    case (c.op)
      ntte_pkg::OP_WRITE: begin
        coef[c.idx] = (c.val >= ntte_pkg::MOD_Q) ? c.val - ntte_pkg::MOD_Q : c.val;
        n_write++;
      end
      ntte_pkg::OP_XFORM: begin
        run_ntt();
        r.value = '0;
        r.index = '0;
        r.done = 1'b1;
        rsp_q.push_back(r);
        n_xform++;
      end
      ntte_pkg::OP_READ: begin
        r.value = coef[c.idx];
        r.index = c.idx;
        r.done = 1'b0;
        rsp_q.push_back(r);
        n_read++;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        c.op = in_tuser;
        c.idx = in_tdata[7:0];
        c.val = in_tdata[19:8];
        apply_cmd(c);
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= c.op;
          in_tdata <= {4'b0, c.val, c.idx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt <= hold_req;
      hold_req <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t e;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (rsp_q.size() == 0) begin
        $error("unexpected result word value=%0d index=%0d done=%0b",
               out_tdata[11:0], out_tdata[19:12], out_tuser);
        errors++;
      end else begin
        e = rsp_q.pop_front();
        if (out_tdata[11:0] !== e.value) begin
          $error("read_value expected %0d got %0d", e.value, out_tdata[11:0]);
          errors++;
        end
        if (out_tdata[19:12] !== e.index) begin
          $error("read_index expected %0d got %0d", e.index, out_tdata[19:12]);
          errors++;
        end
        if (out_tuser !== e.done) begin
          $error("transform_done expected %0b got %0b", e.done, out_tuser);
          errors++;
        end
      end
    end
    out_tready <= (hold_cnt == 0 && hold_req == 0) && $urandom_range(99) >= recv_idle_pct;
  end

  always @(posedge clk) begin
    if (cycles > 4000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push(logic [1:0] op, logic [7:0] idx, logic [11:0] val);
    cmd_t c;
    c.op = op;
    c.idx = idx;
    c.val = val;
    cmd_q.push_back(c);
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || in_tvalid || rsp_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    inv_mode = m;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(999);
      if (r < 15) push(ntte_pkg::OP_XFORM, 8'($urandom), 12'($urandom));
      else if (r < 25) push(ntte_pkg::OP_NOP, 8'($urandom), 12'($urandom));
      else if (r < 510) push(ntte_pkg::OP_WRITE, 8'($urandom), 12'($urandom_range(4095)));
      else push(ntte_pkg::OP_READ, 8'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    inv_mode = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cnt = 0;
    hold_req = 0;
    errors = 0;
    n_xform = 0;
    n_read = 0;
    n_write = 0;
    cycles = 0;
    for (int i = 0; i < ntte_pkg::NPTS; i++) coef[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, reduction on entry, ignored op, both transform modes
    push(ntte_pkg::OP_READ, 8'd0, 12'd0);
    push(ntte_pkg::OP_READ, 8'd255, 12'd0);
    push(ntte_pkg::OP_WRITE, 8'd0, 12'd4095);
    push(ntte_pkg::OP_WRITE, 8'd255, 12'd3329);
    push(ntte_pkg::OP_WRITE, 8'd1, 12'd3328);
    push(ntte_pkg::OP_WRITE, 8'd128, 12'd1);
    push(ntte_pkg::OP_NOP, 8'd1, 12'd5);
    push(ntte_pkg::OP_READ, 8'd0, 12'd0);
    push(ntte_pkg::OP_READ, 8'd255, 12'd0);
    push(ntte_pkg::OP_READ, 8'd1, 12'd0);
    push(ntte_pkg::OP_XFORM, 8'd0, 12'd0);
    push(ntte_pkg::OP_READ, 8'd0, 12'd0);
    push(ntte_pkg::OP_READ, 8'd255, 12'd0);
    drain();
    set_mode(1'b1);
    push(ntte_pkg::OP_XFORM, 8'd255, 12'd4095);
    push(ntte_pkg::OP_READ, 8'd0, 12'd0);
    push(ntte_pkg::OP_READ, 8'd1, 12'd0);
    push(ntte_pkg::OP_READ, 8'd128, 12'd0);
    push(ntte_pkg::OP_READ, 8'd255, 12'd0);
    drain();

    for (int p = 0; p < 4; p++) begin
      set_mode(p[0]);
      send_idle_pct = (p == 1 || p == 3) ? 51 : 0;
      recv_idle_pct = (p == 2 || p == 3) ? 51 : 0;
      if (p == 3) begin
        send_idle_pct = 9;
        recv_idle_pct = 9;
      end
      if (p == 0) begin
        // receiver holds off while reads keep coming
        for (int i = 0; i < 40; i++) push(ntte_pkg::OP_READ, 8'($urandom), 12'd0);
        hold_req = 3000;
      end
      // full load, transform, readback of 64 random indices
      for (int i = 0; i < ntte_pkg::NPTS; i++)
        push(ntte_pkg::OP_WRITE, 8'(i), 12'($urandom_range(4095)));
      push(ntte_pkg::OP_XFORM, 8'd0, 12'd0);
      for (int i = 0; i < 64; i++) push(ntte_pkg::OP_READ, 8'($urandom), 12'd0);
      random_items(150);
      drain();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_mode(1'b0);

    $display("covered %0d writes, %0d reads, %0d transforms in both modes",
             n_write, n_read, n_xform);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
